>>> sv/rwy_pkg.sv
// Package: shared constants, types and helpers for the runway scheduler.
`timescale 1ns / 1ps
`default_nettype none
package rwy_pkg;

  localparam int QUEUE_DEPTH  = 8;
  localparam int MAX_ARRIVALS = 7;
  localparam int TIME_BITS    = 16;
  localparam int MAXQUEUE     = 5;

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int ARR_W  = $clog2(MAX_ARRIVALS + 1);
  localparam int CAP_W  = 4;
  localparam int RUN_W  = 16;
  localparam int STAT_W = 32;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_QUEUE_CAPACITY = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RUN_LENGTH     = CFG_IDX_W'(1);

  localparam logic [RUN_W-1:0] RUN_LEN_RESET = '1;

  typedef enum logic [1:0] {
    KIND_IDLE    = 2'd0,
    KIND_LANDING = 2'd1,
    KIND_TAKEOFF = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FILL,
    S_READ,
    S_SERVE
  } state_t;

  // one tick's worth of counter updates, applied on commit
  typedef struct packed {
    logic                 commit;
    logic                 active;
    kind_t                kind;
    logic [TIME_BITS-1:0] wait_val;
    logic [ARR_W:0]       arrivals;
    logic [ARR_W:0]       refused;
  } stat_upd_t;

  typedef struct packed {
    logic [STAT_W-1:0] total;
    logic [STAT_W-1:0] landed;
    logic [STAT_W-1:0] departed;
    logic [STAT_W-1:0] refused;
    logic [STAT_W-1:0] idle;
    logic [STAT_W-1:0] lwait;
    logic [STAT_W-1:0] twait;
  } stat_vals_t;

  function automatic logic [STAT_W-1:0] sat_add(input logic [STAT_W-1:0] a,
                                                input logic [STAT_W-1:0] b);
    logic [STAT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[STAT_W] ? '1 : s[STAT_W-1:0];
  endfunction

  // zero or oversize capacity falls back to the built depth
  function automatic logic [CNT_W-1:0] usable_cap(input logic [CAP_W-1:0] c);
    logic [CNT_W-1:0] r;
    if (c == '0 || c > CAP_W'(QUEUE_DEPTH)) r = CNT_W'(QUEUE_DEPTH);
    else r = CNT_W'(c);
    return r;
  endfunction

endpackage
`default_nettype wire

>>> sv/rwy_ifs.sv
// Interfaces: tick input, result output and configuration write channels.
`timescale 1ns / 1ps
`default_nettype none
interface rwy_in_if;
  import rwy_pkg::*;
  logic             valid;
  logic             ready;
  logic [ARR_W-1:0] landing_arrivals;
  logic [ARR_W-1:0] takeoff_arrivals;
  modport source(output valid, landing_arrivals, takeoff_arrivals, input ready);
  modport sink(input valid, landing_arrivals, takeoff_arrivals, output ready);
endinterface

interface rwy_out_if;
  import rwy_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [1:0]           served_kind;
  logic [TIME_BITS-1:0] served_wait;
  logic [STAT_W-1:0]    total_requests;
  logic [STAT_W-1:0]    landed_count;
  logic [STAT_W-1:0]    departed_count;
  logic [STAT_W-1:0]    refused_count;
  logic [STAT_W-1:0]    idle_ticks;
  logic [STAT_W-1:0]    landing_wait_total;
  logic [STAT_W-1:0]    takeoff_wait_total;
  logic [CNT_W-1:0]     landing_waiting;
  logic [CNT_W-1:0]     takeoff_waiting;
  logic                 run_done;
  modport source(output valid, served_kind, served_wait, total_requests, landed_count,
                 departed_count, refused_count, idle_ticks, landing_wait_total,
                 takeoff_wait_total, landing_waiting, takeoff_waiting, run_done,
                 input ready);
  modport sink(input valid, served_kind, served_wait, total_requests, landed_count,
               departed_count, refused_count, idle_ticks, landing_wait_total,
               takeoff_wait_total, landing_waiting, takeoff_waiting, run_done,
               output ready);
endinterface

interface rwy_cfg_if;
  import rwy_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> sv/two_queue_priority_runway_scheduler_top.sv
// Top level: tick sequencer, two stamp FIFOs, output register and config registers.
//
// One input transaction is one time tick carrying landing and takeoff arrival
// counts. Arrivals are stamped with the tick number and written one per cycle
// into each queue's stamp memory (both queues in parallel), refused ones are
// only counted. The landing head is then served, else the takeoff head, else
// the tick is idle; one result transaction follows each tick.
// The tick then passes through the fill, read and serve steps before the result
// is loaded; the write port of each stamp memory sets the length of the fill
// step, and in_ready returns the cycle after the result is loaded.
// Ticks past run_length only report the frozen totals with run_done set.
// The result sits in an output register; a new tick can be accepted while it
// waits, but that tick is held in its last step until the receiver takes the
// earlier result. The totals fields show the live counters, which move only
// when a new result is loaded.
// Synchronous reset empties both queues, zeroes tick and totals and restores
// queue_capacity 5 and run_length 65535. Config writes are always taken and
// belong only between ticks.
`timescale 1ns / 1ps
`default_nettype none
module two_queue_priority_runway_scheduler_top (
  input wire logic   clk,
  input wire logic   rst_n,
  rwy_in_if.sink     in_ch,
  rwy_out_if.source  out_ch,
  rwy_cfg_if.sink    cfg_ch
);
  import rwy_pkg::*;

  state_t state_r, state_nxt;

  logic [CAP_W-1:0]     qcap_r;
  logic [RUN_W-1:0]     run_len_r;
  logic [TIME_BITS-1:0] tick_r;
  logic [PTR_W-1:0]     lhead_r, ltail_r, thead_r, ttail_r;
  logic [CNT_W-1:0]     lcount_r, tcount_r;
  logic [ARR_W-1:0]     lfill_r, tfill_r;
  logic [ARR_W:0]       arr_r, ref_r;
  logic                 active_r;
  kind_t                kind_r;

  logic                 out_valid_r;
  kind_t                out_kind_r;
  logic [TIME_BITS-1:0] out_wait_r;
  logic [CNT_W-1:0]     out_lwait_r, out_twait_r;
  logic                 out_done_r;

  logic in_ready, accept, lwe, twe, lre, tre, commit;
  logic [TIME_BITS-1:0] lrd, trd, wait_calc, served_wait;
  logic [CNT_W-1:0]     cap, lfree, tfree, lcount_pop, tcount_pop;
  logic [ARR_W-1:0]     lacc, tacc;
  stat_upd_t            upd;
  stat_vals_t           vals;

  // arrival acceptance against the usable capacity
  always_comb begin
    cap   = usable_cap(qcap_r);
    lfree = (lcount_r >= cap) ? '0 : cap - lcount_r;
    tfree = (tcount_r >= cap) ? '0 : cap - tcount_r;
    lacc  = (CNT_W'(in_ch.landing_arrivals) < lfree) ? in_ch.landing_arrivals
                                                      : ARR_W'(lfree);
    tacc  = (CNT_W'(in_ch.takeoff_arrivals) < tfree) ? in_ch.takeoff_arrivals
                                                      : ARR_W'(tfree);
  end

  assign accept = in_ch.valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = S_FILL;
      S_FILL:  if (lfill_r <= ARR_W'(1) && tfill_r <= ARR_W'(1)) state_nxt = S_READ;
      S_READ:  state_nxt = S_SERVE;
      S_SERVE: if (commit) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    lwe      = 1'b0;
    twe      = 1'b0;
    lre      = 1'b0;
    tre      = 1'b0;
    commit   = 1'b0;
    unique case (state_r)
      S_IDLE:  in_ready = 1'b1;
      S_FILL: begin
        lwe = (lfill_r != '0);
        twe = (tfill_r != '0);
      end
      S_READ: begin
        // reads are issued in the step after the last write, so no forwarding is needed
        lre = active_r && (lcount_r != '0);
        tre = active_r && (lcount_r == '0) && (tcount_r != '0);
      end
      S_SERVE: commit = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  rwy_stamp_ram u_land_ram (
    .clk(clk), .we(lwe), .waddr(ltail_r), .wdata(tick_r),
    .re(lre), .raddr(lhead_r), .rdata(lrd)
  );

  rwy_stamp_ram u_take_ram (
    .clk(clk), .we(twe), .waddr(ttail_r), .wdata(tick_r),
    .re(tre), .raddr(thead_r), .rdata(trd)
  );

  assign wait_calc   = tick_r - ((kind_r == KIND_LANDING) ? lrd : trd);
  assign served_wait = (kind_r == KIND_IDLE) ? '0 : wait_calc;
  assign lcount_pop  = lcount_r - CNT_W'(kind_r == KIND_LANDING);
  assign tcount_pop  = tcount_r - CNT_W'(kind_r == KIND_TAKEOFF);

  always_comb begin
    upd.commit   = commit;
    upd.active   = active_r;
    upd.kind     = kind_r;
    upd.wait_val = served_wait;
    upd.arrivals = arr_r;
    upd.refused  = ref_r;
  end

  rwy_stats u_stats (.clk(clk), .rst_n(rst_n), .upd(upd), .vals(vals));

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      qcap_r      <= CAP_W'(MAXQUEUE);
      run_len_r   <= RUN_LEN_RESET;
      tick_r      <= '0;
      lhead_r     <= '0;
      ltail_r     <= '0;
      lcount_r    <= '0;
      thead_r     <= '0;
      ttail_r     <= '0;
      tcount_r    <= '0;
      lfill_r     <= '0;
      tfill_r     <= '0;
      active_r    <= 1'b0;
      kind_r      <= KIND_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        unique case (cfg_ch.index)
          REG_QUEUE_CAPACITY: qcap_r <= cfg_ch.data[CAP_W-1:0];
          REG_RUN_LENGTH:     run_len_r <= cfg_ch.data[RUN_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        if (RUN_W'(tick_r) < run_len_r) begin
          active_r <= 1'b1;
          tick_r   <= tick_r + TIME_BITS'(1);
          lfill_r  <= lacc;
          tfill_r  <= tacc;
        end else begin
          active_r <= 1'b0;
          lfill_r  <= '0;
          tfill_r  <= '0;
        end
      end
      if (lwe) begin
        ltail_r  <= ltail_r + PTR_W'(1);
        lcount_r <= lcount_r + CNT_W'(1);
        lfill_r  <= lfill_r - ARR_W'(1);
      end
      if (twe) begin
        ttail_r  <= ttail_r + PTR_W'(1);
        tcount_r <= tcount_r + CNT_W'(1);
        tfill_r  <= tfill_r - ARR_W'(1);
      end
      if (state_r == S_READ) begin
        kind_r <= lre ? KIND_LANDING : (tre ? KIND_TAKEOFF : KIND_IDLE);
      end
      if (commit) begin
        lcount_r <= lcount_pop;
        tcount_r <= tcount_pop;
        if (kind_r == KIND_LANDING) lhead_r <= lhead_r + PTR_W'(1);
        if (kind_r == KIND_TAKEOFF) thead_r <= thead_r + PTR_W'(1);
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      if (RUN_W'(tick_r) < run_len_r) begin
        arr_r <= (ARR_W+1)'(in_ch.landing_arrivals) + (ARR_W+1)'(in_ch.takeoff_arrivals);
        ref_r <= (ARR_W+1)'(in_ch.landing_arrivals - lacc)
               + (ARR_W+1)'(in_ch.takeoff_arrivals - tacc);
      end else begin
        arr_r <= '0;
        ref_r <= '0;
      end
    end
    if (commit) begin
      out_kind_r  <= kind_r;
      out_wait_r  <= served_wait;
      out_lwait_r <= lcount_pop;
      out_twait_r <= tcount_pop;
      out_done_r  <= (RUN_W'(tick_r) >= run_len_r);
    end
  end

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid              = out_valid_r;
  assign out_ch.served_kind        = out_kind_r;
  assign out_ch.served_wait        = out_wait_r;
  assign out_ch.total_requests     = vals.total;
  assign out_ch.landed_count       = vals.landed;
  assign out_ch.departed_count     = vals.departed;
  assign out_ch.refused_count      = vals.refused;
  assign out_ch.idle_ticks         = vals.idle;
  assign out_ch.landing_wait_total = vals.lwait;
  assign out_ch.takeoff_wait_total = vals.twait;
  assign out_ch.landing_waiting    = out_lwait_r;
  assign out_ch.takeoff_waiting    = out_twait_r;
  assign out_ch.run_done           = out_done_r;

  a_lring: assert property (@(posedge clk) disable iff (!rst_n)
    PTR_W'(ltail_r - lhead_r) == lcount_r[PTR_W-1:0])
    else $error("landing pointers disagree with occupancy");

  a_tring: assert property (@(posedge clk) disable iff (!rst_n)
    PTR_W'(ttail_r - thead_r) == tcount_r[PTR_W-1:0])
    else $error("takeoff pointers disagree with occupancy");

  a_ldepth: assert property (@(posedge clk) disable iff (!rst_n)
    lcount_r <= CNT_W'(QUEUE_DEPTH) && tcount_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue occupancy beyond built depth");

  a_serve_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SERVE && kind_r == KIND_LANDING) |-> lcount_r != '0)
    else $error("landing served from an empty queue");

  a_out_from_serve: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_SERVE))
    else $error("result raised outside the serve step");

endmodule
`default_nettype wire

>>> sv/rwy_stamp_ram.sv
// Arrival stamp memory: one write port, one read port, registered read data.
`timescale 1ns / 1ps
`default_nettype none
module rwy_stamp_ram (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [rwy_pkg::PTR_W-1:0]     waddr,
  input  wire logic [rwy_pkg::TIME_BITS-1:0] wdata,
  input  wire logic                         re,
  input  wire logic [rwy_pkg::PTR_W-1:0]     raddr,
  output      logic [rwy_pkg::TIME_BITS-1:0] rdata
);
  import rwy_pkg::*;

  logic [TIME_BITS-1:0] mem_r [QUEUE_DEPTH];
  logic [TIME_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

>>> sv/rwy_stats.sv
// Saturating running totals, updated once per committed active tick.
`timescale 1ns / 1ps
`default_nettype none
module rwy_stats (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rwy_pkg::stat_upd_t  upd,
  output      rwy_pkg::stat_vals_t vals
);
  import rwy_pkg::*;

  stat_vals_t vals_r, vals_nxt;
  logic [STAT_W-1:0] wait_ext;

  assign wait_ext = STAT_W'(upd.wait_val);

  always_comb begin
    vals_nxt = vals_r;
    if (upd.commit && upd.active) begin
      vals_nxt.total   = sat_add(vals_r.total, STAT_W'(upd.arrivals));
      vals_nxt.refused = sat_add(vals_r.refused, STAT_W'(upd.refused));
      unique case (upd.kind)
        KIND_LANDING: begin
          vals_nxt.landed = sat_add(vals_r.landed, STAT_W'(1));
          vals_nxt.lwait  = sat_add(vals_r.lwait, wait_ext);
        end
        KIND_TAKEOFF: begin
          vals_nxt.departed = sat_add(vals_r.departed, STAT_W'(1));
          vals_nxt.twait    = sat_add(vals_r.twait, wait_ext);
        end
        default: begin
          vals_nxt.idle = sat_add(vals_r.idle, STAT_W'(1));
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vals_r <= '0;
    end else begin
      vals_r <= vals_nxt;
    end
  end

  assign vals = vals_r;

endmodule
`default_nettype wire
